// ===== rtl/core/median_adc_key_decoder_macros.svh =====
// ----------------------------------------------------------------------------
// median_adc_key_decoder_macros
// assertion macros shared by the key decoder checker
// ----------------------------------------------------------------------------
`ifndef MEDIAN_ADC_KEY_DECODER_MACROS_SVH
`define MEDIAN_ADC_KEY_DECODER_MACROS_SVH

// implication checked on every clock edge outside reset
`define MAKD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// invariant checked on every clock edge outside reset
`define MAKD_ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed");

`endif

// ===== rtl/core/makd_pkg.sv =====
// ----------------------------------------------------------------------------
// makd_pkg
// types, constants and key decode function of the median keypad decoder
// ----------------------------------------------------------------------------
package makd_pkg;

	localparam int SAMPLES_DEF = 8;
	localparam int SAMPLE_W    = 12;
	localparam int KEY_W       = 4;

	// key codes
	localparam logic [KEY_W-1:0] KEY_NONE  = 4'd0;
	localparam logic [KEY_W-1:0] KEY_ONE   = 4'd1;
	localparam logic [KEY_W-1:0] KEY_TWO   = 4'd2;
	localparam logic [KEY_W-1:0] KEY_THREE = 4'd3;
	localparam logic [KEY_W-1:0] KEY_FOUR  = 4'd4;
	localparam logic [KEY_W-1:0] KEY_FIVE  = 4'd5;
	localparam logic [KEY_W-1:0] KEY_SIX   = 4'd6;
	localparam logic [KEY_W-1:0] KEY_SEVEN = 4'd7;
	localparam logic [KEY_W-1:0] KEY_EIGHT = 4'd8;

	// ladder window bounds, inclusive
	localparam logic [SAMPLE_W-1:0] K1_HI = 12'h020;
	localparam logic [SAMPLE_W-1:0] K2_LO = 12'h0B0;
	localparam logic [SAMPLE_W-1:0] K2_HI = 12'h100;
	localparam logic [SAMPLE_W-1:0] K3_LO = 12'h240;
	localparam logic [SAMPLE_W-1:0] K3_HI = 12'h300;
	localparam logic [SAMPLE_W-1:0] K4_LO = 12'h3B0;
	localparam logic [SAMPLE_W-1:0] K4_HI = 12'h450;
	localparam logic [SAMPLE_W-1:0] K5_LO = 12'h500;
	localparam logic [SAMPLE_W-1:0] K5_HI = 12'h600;
	localparam logic [SAMPLE_W-1:0] K6_LO = 12'h700;
	localparam logic [SAMPLE_W-1:0] K6_HI = 12'h800;
	localparam logic [SAMPLE_W-1:0] K7_LO = 12'h840;
	localparam logic [SAMPLE_W-1:0] K7_HI = 12'h940;
	localparam logic [SAMPLE_W-1:0] K8_HI = 12'hB50;

	// what one cell hands to its right neighbor
	typedef struct packed {
		logic                gt;
		logic [SAMPLE_W-1:0] val;
	} makd_link_t;

	function automatic logic [KEY_W-1:0] decode_key(input logic [SAMPLE_W-1:0] m);
		logic [KEY_W-1:0] k;
		priority if (m <= K1_HI)                 k = KEY_ONE;
		else if (m >= K2_LO && m <= K2_HI)      k = KEY_TWO;
		else if (m >= K3_LO && m <= K3_HI)      k = KEY_THREE;
		else if (m >= K4_LO && m <= K4_HI)      k = KEY_FOUR;
		else if (m >= K5_LO && m <= K5_HI)      k = KEY_FIVE;
		else if (m >= K6_LO && m <= K6_HI)      k = KEY_SIX;
		else if (m >= K7_LO && m <= K7_HI)      k = KEY_SEVEN;
		else if (m <= K8_HI)                    k = KEY_EIGHT;
		else                                    k = KEY_NONE;
		return k;
	endfunction

endpackage

// ===== rtl/core/median_adc_key_decoder.sv =====
// ----------------------------------------------------------------------------
// median_adc_key_decoder
// median filter over a batch of ladder keypad samples, decoded to a key code
// ----------------------------------------------------------------------------
// usage
//   input: drive sample with start high; a beat is taken on any edge where
//   start is high and busy is low. busy stays low, so a sample can be given
//   on every cycle without gaps.
//   output: done is high for exactly one cycle with key_code and
//   median_value; the receiver cannot stall and must take it then.
// timing
//   one sample per cycle, set by the row of sort cells which all update in
//   the same cycle from a broadcast compare against the new sample.
//   every SAMPLES beats give one result; the edge that takes the last sample
//   of a batch settles the row and raises fire_s1, the next edge registers
//   the mean, key and done strobe. the next batch may start right away; the
//   result stage reads the row before the first sample of the next batch
//   overwrites it.
// reset
//   arst_n clears the batch count and the result strobe; the cells hold no
//   reset and are only read once the batch has filled them.
// ----------------------------------------------------------------------------
module median_adc_key_decoder #(
	parameter int SAMPLES = makd_pkg::SAMPLES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [makd_pkg::SAMPLE_W-1:0] sample,
	output logic                          done,
	output logic [makd_pkg::KEY_W-1:0]    key_code,
	output logic [makd_pkg::SAMPLE_W-1:0] median_value
);
	import makd_pkg::*;

	// batch counter only needs to reach SAMPLES-1
	localparam int CNT_W  = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
	// middle pair; equal indexes for an odd count
	localparam int LO_IDX = (SAMPLES - 1) / 2;
	localparam int HI_IDX = SAMPLES / 2;

	logic             accept;
	logic             last;
	logic [CNT_W-1:0] count_q;
	logic             fire_s1;
	logic [SAMPLES-1:0] filled;
	makd_link_t       link [SAMPLES+1];

	// the row never blocks: every start is a beat
	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign last   = (count_q == CNT_W'(SAMPLES - 1));

	// batch count, wraps on the last sample of a batch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			fire_s1 <= 1'b0;
		end else begin
			fire_s1 <= accept && last;
			if (accept) begin
				count_q <= last ? '0 : count_q + 1'b1;
			end
		end
	end

	// nothing enters the row from the left end
	assign link[0] = '{gt: 1'b0, val: '0};

	// sort row: slot i holds the i-th smallest sample of the batch so far
	for (genvar i = 0; i < SAMPLES; i++) begin : g_cell
		assign filled[i] = ({1'b0, count_q} > (CNT_W + 1)'(i));

		makd_cell u_cell (
			.clk    (clk),
			.load   (accept),
			.filled (filled[i]),
			.s      (sample),
			.left   (link[i]),
			.right  (link[i+1])
		);
	end

	// mean of the middle pair, decode and registered result
	makd_median u_median (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (fire_s1),
		.mid_lo       (link[LO_IDX+1].val),
		.mid_hi       (link[HI_IDX+1].val),
		.done         (done),
		.key_code     (key_code),
		.median_value (median_value)
	);

endmodule

// ===== rtl/core/makd_cell.sv =====
// ----------------------------------------------------------------------------
// makd_cell
// one slot of the insertion-sort row: keeps or shifts right or takes the sample
// ----------------------------------------------------------------------------
module makd_cell (
	input  logic                          clk,
	input  logic                          load,
	input  logic                          filled,
	input  logic [makd_pkg::SAMPLE_W-1:0] s,
	input  makd_pkg::makd_link_t          left,
	output makd_pkg::makd_link_t          right
);
	import makd_pkg::*;

	logic [SAMPLE_W-1:0] val_q;
	logic                gt;

	// only a filled slot holding a larger value moves right
	assign gt        = filled && (val_q > s);
	assign right.gt  = gt;
	assign right.val = val_q;

	always_ff @(posedge clk) begin
		if (load) begin
			if (left.gt) begin
				val_q <= left.val;
			end else if (gt || !filled) begin
				val_q <= s;
			end
		end
	end

endmodule

// ===== rtl/core/makd_median.sv =====
// ----------------------------------------------------------------------------
// makd_median
// middle-pair mean, key decode and the result register
// ----------------------------------------------------------------------------
module makd_median (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          fire,
	input  logic [makd_pkg::SAMPLE_W-1:0] mid_lo,
	input  logic [makd_pkg::SAMPLE_W-1:0] mid_hi,
	output logic                          done,
	output logic [makd_pkg::KEY_W-1:0]    key_code,
	output logic [makd_pkg::SAMPLE_W-1:0] median_value
);
	import makd_pkg::*;

	logic [SAMPLE_W:0]   sum;
	logic [SAMPLE_W-1:0] med;
	logic                done_q;
	logic [KEY_W-1:0]    key_q;
	logic [SAMPLE_W-1:0] med_q;

	// for an odd count both inputs are the same cell, so the mean is exact
	assign sum = {1'b0, mid_lo} + {1'b0, mid_hi};
	assign med = sum[SAMPLE_W:1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= fire;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			key_q <= decode_key(med);
			med_q <= med;
		end
	end

	assign done         = done_q;
	assign key_code     = key_q;
	assign median_value = med_q;

endmodule

// ===== rtl/core/makd_checker.sv =====
// ----------------------------------------------------------------------------
// makd_checker
// port-level checks of the median keypad decoder, bound to the top level
// ----------------------------------------------------------------------------
`include "median_adc_key_decoder_macros.svh"

module makd_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          done,
	input logic [makd_pkg::KEY_W-1:0]    key_code,
	input logic [makd_pkg::SAMPLE_W-1:0] median_value
);
	import makd_pkg::*;

	// a result follows the beat that closed its batch, through fire_s1 and the result register
	`MAKD_ASSERT_IMPL(a_done_after_beat, clk, arst_n, done, $past(start && !busy, 2))
	// no key exactly when the median is above the ladder range
	`MAKD_ASSERT_IMPL(a_none_range, clk, arst_n, done, (key_code == KEY_NONE) == (median_value > K8_HI))
	// key one exactly when the median is at the bottom of the ladder
	`MAKD_ASSERT_IMPL(a_one_range, clk, arst_n, done, (key_code == KEY_ONE) == (median_value <= K1_HI))
	// key codes stay within the keypad
	`MAKD_ASSERT_IMPL(a_key_max, clk, arst_n, done, key_code <= KEY_EIGHT)

endmodule

bind median_adc_key_decoder makd_checker u_makd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.key_code     (key_code),
	.median_value (median_value)
);

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// regression bench for the median ladder keypad decoder: samples are fed
// through the start/busy handshake with random gaps, every batch is sorted
// and decoded by an independent predictor, and each done strobe is checked
// against the oldest predicted key code and median
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import makd_pkg::*;

	localparam int BATCH       = SAMPLES_DEF;
	localparam int CYCLE_LIMIT = 200000;
	localparam int RAND_BATCHES = 88;

	// ladder windows, bounds inclusive, checked in this order
	localparam int WIN1_HI = 'h020;
	localparam int WIN2_LO = 'h0B0;
	localparam int WIN2_HI = 'h100;
	localparam int WIN3_LO = 'h240;
	localparam int WIN3_HI = 'h300;
	localparam int WIN4_LO = 'h3B0;
	localparam int WIN4_HI = 'h450;
	localparam int WIN5_LO = 'h500;
	localparam int WIN5_HI = 'h600;
	localparam int WIN6_LO = 'h700;
	localparam int WIN6_HI = 'h800;
	localparam int WIN7_LO = 'h840;
	localparam int WIN7_HI = 'h940;
	localparam int WIN8_HI = 'hB50;

	// idle styles for the sender, picked per batch
	typedef enum int {IDLE_NONE, IDLE_FULL, IDLE_SPARSE} idle_style_t;

	typedef struct {
		logic [SAMPLE_W-1:0] value;
		int unsigned         gap;
	} adc_beat_t;

	typedef struct {
		logic [KEY_W-1:0]    key;
		logic [SAMPLE_W-1:0] median;
	} key_result_t;

	logic                clk    = 1'b0;
	logic                arst_n = 1'b0;
	logic                start  = 1'b0;
	logic                busy;
	logic [SAMPLE_W-1:0] sample = '0;
	logic                done;
	logic [KEY_W-1:0]    key_code;
	logic [SAMPLE_W-1:0] median_value;

	// stimulus and prediction state
	adc_beat_t           adc_beats [$];
	key_result_t         expected_keys [$];
	logic [SAMPLE_W-1:0] batch_vals [BATCH];
	logic [SAMPLE_W-1:0] edge_pts [$];
	idle_style_t         idle_style = IDLE_NONE;

	// predictor copy of the sorted row
	logic [SAMPLE_W-1:0] ladder_row [BATCH];
	int                  ladder_fill = 0;

	// driver and monitor bookkeeping
	adc_beat_t           cur_beat;
	bit                  holding     = 1'b0;
	int                  beats_taken = 0;
	int                  beats_used  = 0;
	int unsigned         gap_left    = 0;
	key_result_t         exp_r;
	int                  err_count   = 0;
	int                  cycle_count = 0;

	median_adc_key_decoder #(
		.SAMPLES(BATCH)
	) uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.sample      (sample),
		.done        (done),
		.key_code    (key_code),
		.median_value(median_value)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
	end

	// ------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------

	// ladder decode of a median, first matching window wins
	function automatic logic [KEY_W-1:0] ladder_key(input int m);
		if (m <= WIN1_HI) return KEY_ONE;
		if (m >= WIN2_LO && m <= WIN2_HI) return KEY_TWO;
		if (m >= WIN3_LO && m <= WIN3_HI) return KEY_THREE;
		if (m >= WIN4_LO && m <= WIN4_HI) return KEY_FOUR;
		if (m >= WIN5_LO && m <= WIN5_HI) return KEY_FIVE;
		if (m >= WIN6_LO && m <= WIN6_HI) return KEY_SIX;
		if (m >= WIN7_LO && m <= WIN7_HI) return KEY_SEVEN;
		// anything else up to the top window, gaps included, is key eight
		if (m <= WIN8_HI) return KEY_EIGHT;
		return KEY_NONE;
	endfunction

	// insert one accepted sample; a full row yields one expected result
	function automatic void take_sample(input logic [SAMPLE_W-1:0] s);
		int          pos;
		int          mid;
		key_result_t r;
		pos = ladder_fill;
		while (pos > 0 && ladder_row[pos-1] > s) begin
			ladder_row[pos] = ladder_row[pos-1];
			pos--;
		end
		ladder_row[pos] = s;
		ladder_fill++;
		if (ladder_fill == BATCH) begin
			if (BATCH % 2 == 0)
				// int sum so two large middles do not wrap
				mid = (int'(ladder_row[BATCH/2-1]) + int'(ladder_row[BATCH/2])) / 2;
			else
				mid = int'(ladder_row[BATCH/2]);
			r.key    = ladder_key(mid);
			r.median = mid[SAMPLE_W-1:0];
			expected_keys.push_back(r);
			// next batch starts on the very next beat
			ladder_fill = 0;
		end
	endfunction

	function automatic void note_fail(input string msg);
		err_count++;
		if (err_count <= 10) $display("mismatch at cycle %0d: %s", cycle_count, msg);
	endfunction

	// ------------------------------------------------------------------
	// stimulus building
	// ------------------------------------------------------------------

	function automatic int unsigned draw_gap();
		case (idle_style)
			IDLE_NONE: begin
				return 0;
			end
			IDLE_FULL: begin
				return $urandom_range(0, 19);
			end
			default: begin
				// mostly back to back with an occasional hole
				return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 19) : 0;
			end
		endcase
	endfunction

	function automatic void shuffle_batch();
		int unsigned         j;
		logic [SAMPLE_W-1:0] t;
		for (int i = BATCH - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = batch_vals[i];
			batch_vals[i] = batch_vals[j];
			batch_vals[j] = t;
		end
	endfunction

	function automatic void queue_batch();
		adc_beat_t b;
		for (int i = 0; i < BATCH; i++) begin
			b.value = batch_vals[i];
			b.gap   = draw_gap();
			adc_beats.push_back(b);
		end
	endfunction

	// batch whose middle pair averages (truncated) to m
	function automatic void build_targeted(input int m);
		int d;
		int lo_mid;
		int hi_mid;
		d = $urandom_range(0, 3);
		if (d > m) d = m;
		lo_mid = m - d;
		// odd spread exercises the truncating divide
		hi_mid = m + d + $urandom_range(0, 1);
		if (hi_mid > 4095) begin
			hi_mid = 4095;
			lo_mid = 2 * m - hi_mid;
		end
		for (int i = 0; i < BATCH; i++) begin
			if (i < BATCH/2 - 1)
				batch_vals[i] = SAMPLE_W'($urandom_range(0, lo_mid));
			else if (i == BATCH/2 - 1)
				batch_vals[i] = SAMPLE_W'(lo_mid);
			else if (i == BATCH/2)
				batch_vals[i] = SAMPLE_W'(hi_mid);
			else
				batch_vals[i] = SAMPLE_W'($urandom_range(hi_mid, 4095));
		end
		shuffle_batch();
	endfunction

	// a pressed key: noisy samples around one ladder level, a couple of outliers
	function automatic void build_cluster();
		int centers [9];
		int c;
		int v;
		centers = '{'h010, 'h0D8, 'h2A0, 'h400, 'h580, 'h780, 'h8C0, 'hA00, 'hD00};
		c = centers[$urandom_range(0, 8)];
		for (int i = 0; i < BATCH; i++) begin
			v = c + $urandom_range(0, 'h30) - 'h18;
			if (v < 0) v = 0;
			if (v > 4095) v = 4095;
			batch_vals[i] = SAMPLE_W'(v);
		end
		for (int k = $urandom_range(0, 2); k > 0; k--)
			batch_vals[$urandom_range(0, BATCH - 1)] = SAMPLE_W'($urandom_range(0, 4095));
	endfunction

	// ------------------------------------------------------------------
	// driver: inputs move on the falling edge
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n) begin
			// last rising edge took the held beat
			if (beats_used != beats_taken) begin
				beats_used = beats_taken;
				holding    = 1'b0;
			end
			if (!holding && adc_beats.size() != 0) begin
				cur_beat = adc_beats.pop_front();
				gap_left = cur_beat.gap;
				holding  = 1'b1;
			end
			if (holding && gap_left == 0) begin
				start  <= 1'b1;
				sample <= cur_beat.value;
			end else begin
				start  <= 1'b0;
				// junk on the bus while idle must be ignored
				sample <= SAMPLE_W'($urandom_range(0, 4095));
				if (holding) gap_left--;
			end
		end
	end

	// ------------------------------------------------------------------
	// monitor: check the strobe first, then record the beat taken here,
	// so a result that shows up too early is flagged as unexpected
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (done === 1'b1) begin
				if (expected_keys.size() == 0) begin
					note_fail($sformatf("unexpected result key %0d median 0x%03h",
						key_code, median_value));
				end else begin
					exp_r = expected_keys.pop_front();
					if (key_code !== exp_r.key)
						note_fail($sformatf("key_code expected %0d got %0d (median 0x%03h)",
							exp_r.key, key_code, exp_r.median));
					if (median_value !== exp_r.median)
						note_fail($sformatf("median_value expected 0x%03h got 0x%03h",
							exp_r.median, median_value));
				end
			end
			if (start && busy === 1'b0) begin
				beats_taken++;
				take_sample(sample);
			end
		end
	end

	// ------------------------------------------------------------------
	// stimulus and end of run
	// ------------------------------------------------------------------
	initial begin
		edge_pts = '{'h000, 'h020, 'h021, 'h0AF, 'h0B0, 'h100, 'h101, 'h23F, 'h240,
			'h300, 'h301, 'h3AF, 'h3B0, 'h450, 'h451, 'h4FF, 'h500, 'h600, 'h601,
			'h6FF, 'h700, 'h800, 'h801, 'h83F, 'h840, 'h940, 'h941, 'hB50, 'hB51,
			'hFFF};

		// directed: all zeros, back to back (floor, equal samples)
		idle_style = IDLE_NONE;
		for (int i = 0; i < BATCH; i++) batch_vals[i] = 12'h000;
		queue_batch();
		// directed: all full scale, middle sum needs the 13th bit, no key
		for (int i = 0; i < BATCH; i++) batch_vals[i] = 12'hFFF;
		queue_batch();
		// directed: strictly falling order, each beat lands at the head of the row;
		// middle pair 0x840/0x841 truncates onto the key seven floor
		idle_style = IDLE_FULL;
		batch_vals = '{12'hFFF, 12'hAAA, 12'h941, 12'h841, 12'h840, 12'h555,
			12'h001, 12'h000};
		queue_batch();

		// random batches: boundary medians, random medians, pressed keys, and pure noise
		for (int n = 0; n < RAND_BATCHES; n++) begin
			idle_style = idle_style_t'($urandom_range(0, 2));
			case ($urandom_range(0, 3))
				0: begin
					build_targeted(int'(edge_pts[$urandom_range(0, edge_pts.size() - 1)]));
				end
				1: begin
					build_targeted($urandom_range(0, 4095));
				end
				2: begin
					build_cluster();
				end
				default: begin
					for (int i = 0; i < BATCH; i++)
						batch_vals[i] = SAMPLE_W'($urandom_range(0, 4095));
				end
			endcase
			queue_batch();
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// all beats taken and every batch result seen
		while (adc_beats.size() != 0 || holding || expected_keys.size() != 0)
			@(posedge clk);
		// run on past the result register to catch stray strobes
		repeat (8) @(posedge clk);

		if (err_count == 0 && expected_keys.size() == 0) begin
			$display("median_adc_key_decoder regression: pass");
		end else begin
			$display("median_adc_key_decoder regression: fail");
		end
		$finish;
	end

	// watchdog
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("median_adc_key_decoder regression: fail");
		$finish;
	end

endmodule
